[rtl/sdes_pkg.sv]
// shared types, constants and bit-selection helpers for the s-des cbc byte cipher
`timescale 1ns / 1ps

package sdes_pkg;

	localparam int KEY_W   = 10;
	localparam int BYTE_W  = 8;
	localparam int HALF_W  = 4;
	localparam int CFG_W   = 10;
	localparam int CFG_IDX_W = 2;

	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [HALF_W-1:0] half_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// configuration register indexes
	localparam cfg_idx_t CFG_CIPHER_KEY   = 2'd0;
	localparam cfg_idx_t CFG_INIT_VECTOR  = 2'd1;
	localparam cfg_idx_t CFG_DECRYPT_MODE = 2'd2;

	// bit positions (0 = lsb), listed from result msb down to lsb
	typedef logic [3:0] sel_arr_t [BYTE_W];

	localparam sel_arr_t SEL_KEY_ONE = '{4'd9, 4'd3, 4'd1, 4'd6, 4'd2, 4'd7, 4'd0, 4'd4};
	localparam sel_arr_t SEL_KEY_TWO = '{4'd2, 4'd7, 4'd4, 4'd5, 4'd0, 4'd8, 4'd1, 4'd9};
	localparam sel_arr_t SEL_IP      = '{4'd6, 4'd2, 4'd5, 4'd7, 4'd4, 4'd0, 4'd3, 4'd1};
	localparam sel_arr_t SEL_IP_INV  = '{4'd4, 4'd7, 4'd5, 4'd3, 4'd1, 4'd6, 4'd0, 4'd2};

	typedef logic [1:0] sbox_arr_t [16];

	localparam sbox_arr_t SBOX_ZERO = '{
		2'd1, 2'd0, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0,
		2'd0, 2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd3, 2'd2
	};
	localparam sbox_arr_t SBOX_ONE = '{
		2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3,
		2'd3, 2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3
	};

	// gather eight bits of a key-wide source by a fixed selection
	function automatic byte_t pick_bits(input key_t src, input sel_arr_t sel);
		byte_t acc;
		acc = '0;
		for (int i = 0; i < BYTE_W; i++) begin
			acc[BYTE_W-1-i] = src[sel[i]];
		end
		return acc;
	endfunction

endpackage

[rtl/sdes_round.sv]
// s-des round function: expansion, subkey mix, two s-boxes and p4
`timescale 1ns / 1ps

module sdes_round (
	input  sdes_pkg::half_t half_in,
	input  sdes_pkg::byte_t subkey,
	output sdes_pkg::half_t f_out
);
	import sdes_pkg::*;

	byte_t      ep;
	logic [3:0] idx0;
	logic [3:0] idx1;
	logic [1:0] s0;
	logic [1:0] s1;

	always_comb begin
		// expansion/permutation of the half, then subkey mix
		ep   = {half_in[0], half_in[3], half_in[2], half_in[1],
			half_in[2], half_in[1], half_in[0], half_in[3]} ^ subkey;
		idx0 = {ep[7], ep[4], ep[6], ep[5]};
		idx1 = {ep[3], ep[0], ep[2], ep[1]};
		s0   = SBOX_ZERO[idx0];
		s1   = SBOX_ONE[idx1];
		f_out = {s0[0], s1[0], s1[1], s0[1]};
	end

endmodule

[rtl/sdes_block.sv]
// s-des block cipher on one byte: ip, two feistel rounds, inverse ip
`timescale 1ns / 1ps

module sdes_block (
	input  sdes_pkg::byte_t din,
	input  sdes_pkg::byte_t key_a,
	input  sdes_pkg::byte_t key_b,
	output sdes_pkg::byte_t dout
);
	import sdes_pkg::*;

	byte_t x;
	half_t f1;
	half_t f2;
	half_t mixed;
	half_t left2;

	assign x = pick_bits({{(KEY_W-BYTE_W){1'b0}}, din}, SEL_IP);

	sdes_round u_round1 (
		.half_in (x[3:0]),
		.subkey  (key_a),
		.f_out   (f1)
	);

	assign mixed = x[7:4] ^ f1;

	// halves swapped between rounds
	sdes_round u_round2 (
		.half_in (mixed),
		.subkey  (key_b),
		.f_out   (f2)
	);

	assign left2 = x[3:0] ^ f2;
	assign dout  = pick_bits({{(KEY_W-BYTE_W){1'b0}}, left2, mixed}, SEL_IP_INV);

endmodule

[rtl/sdes_cbc_byte_cipher_core.sv]
// top level: s-des cbc byte cipher with input register, cipher logic and result register
`timescale 1ns / 1ps

// simplified des in cbc mode, one byte per word. a word enters the input
// register, passes the whole cipher (ip, two feistel rounds, inverse ip)
// plus the cbc xor in combinational logic, and lands in the result register.
// a new byte can be taken every cycle while out_stall is low (one byte per
// clock sustained). the rate is set by the chaining loop: the chain register
// is updated from the cipher output at the same edge that moves a byte into
// the result register, and the next byte reads it in the following cycle.
// encrypt: result = E(data ^ prev), chain keeps the result. decrypt:
// result = D(data) ^ prev with swapped subkeys, chain keeps the incoming
// byte. prev is init_vector when message_start is set, otherwise the chain
// register (zero after reset). configuration registers are written through
// cfg_we/cfg_index/cfg_data and should only be changed while no byte is in
// flight; writes to unused indexes are ignored.
module sdes_cbc_byte_cipher_core (
	input  logic                  clk,
	input  logic                  arst_n,

	// configuration write port
	input  logic                  cfg_we,
	input  sdes_pkg::cfg_idx_t    cfg_index,
	input  logic [sdes_pkg::CFG_W-1:0] cfg_data,

	// input words
	input  logic                  in_valid,
	output logic                  in_stall,
	input  sdes_pkg::byte_t       data_byte,
	input  logic                  message_start,

	// result words
	output logic                  out_valid,
	input  logic                  out_stall,
	output sdes_pkg::byte_t       result_byte
);
	import sdes_pkg::*;

	// configuration registers
	key_t  key_q;
	byte_t iv_q;
	logic  decrypt_q;

	// cbc chain register
	byte_t chain_q;

	// input stage
	logic  valid_s1;
	byte_t data_s1;
	logic  start_s1;

	// result stage
	logic  valid_s2;
	byte_t result_s2;

	// datapath
	byte_t k1;
	byte_t k2;
	byte_t prev;
	byte_t cipher_in;
	byte_t key_a;
	byte_t key_b;
	byte_t cipher_out;
	byte_t result_next;
	byte_t chain_next;

	logic  load_s2;
	logic  load_s1;

	// result register may take a new word when empty or being drained
	assign load_s2  = valid_s1 && (!valid_s2 || !out_stall);
	// input register frees up when its word moves on
	assign in_stall = valid_s1 && !load_s2;
	assign load_s1  = in_valid && !in_stall;

	assign out_valid   = valid_s2;
	assign result_byte = result_s2;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q     <= '0;
			iv_q      <= '0;
			decrypt_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CIPHER_KEY:   key_q     <= cfg_data[KEY_W-1:0];
				CFG_INIT_VECTOR:  iv_q      <= cfg_data[BYTE_W-1:0];
				CFG_DECRYPT_MODE: decrypt_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// subkeys straight from the key register
	assign k1 = pick_bits(key_q, SEL_KEY_ONE);
	assign k2 = pick_bits(key_q, SEL_KEY_TWO);

	always_comb begin
		prev      = start_s1 ? iv_q : chain_q;
		cipher_in = decrypt_q ? data_s1 : (data_s1 ^ prev);
		key_a     = decrypt_q ? k2 : k1;
		key_b     = decrypt_q ? k1 : k2;
	end

	sdes_block u_block (
		.din   (cipher_in),
		.key_a (key_a),
		.key_b (key_b),
		.dout  (cipher_out)
	);

	always_comb begin
		result_next = decrypt_q ? (cipher_out ^ prev) : cipher_out;
		// chain always keeps the ciphertext side of the byte
		chain_next  = decrypt_q ? data_s1 : cipher_out;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			chain_q  <= '0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (load_s2) begin
				valid_s1 <= 1'b0;
			end
			if (load_s2) begin
				valid_s2 <= 1'b1;
				chain_q  <= chain_next;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (load_s1) begin
			data_s1  <= data_byte;
			start_s1 <= message_start;
		end
		if (load_s2) begin
			result_s2 <= result_next;
		end
	end

endmodule

[tb/testbench.sv]
// self-checking testbench for the s-des cbc byte cipher core
`timescale 1ns / 1ps

module testbench;
	import sdes_pkg::*;

	localparam int RANDOM_PHASES   = 8;
	localparam int WORDS_PER_PHASE = 235;
	localparam int PRESSURE_PHASE  = 3;
	localparam int HOLD_CYCLES     = 300;
	localparam int MAX_REPORTS     = 10;

	typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

	// one line of the directed table: either a register write or an input word,
	// with a hand-derived result where it is obvious
	typedef struct {
		row_kind_t           kind;
		cfg_idx_t            reg_idx;
		logic [CFG_W-1:0]    reg_val;
		byte_t               data;
		logic                start;
		bit                  typed;
		byte_t               want;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 23;

	// zero key makes both subkeys zero: 8'h00 enciphers to 8'hf0 and back
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		// no message start since reset: chain register is zero, same as a zero iv
		'{ROW_WORD, CFG_CIPHER_KEY,   10'h000, 8'h00, 1'b0, 1'b1, 8'hF0},
		'{ROW_WORD, CFG_CIPHER_KEY,   10'h000, 8'hFF, 1'b0, 1'b0, 8'h00},
		// restart from the zero iv repeats the first word
		'{ROW_WORD, CFG_CIPHER_KEY,   10'h000, 8'h00, 1'b1, 1'b1, 8'hF0},
		'{ROW_WORD, CFG_CIPHER_KEY,   10'h000, 8'h5A, 1'b0, 1'b0, 8'h00},
		// mode flip mid-message, chain carries on
		'{ROW_CFG,  CFG_DECRYPT_MODE, 10'h001, 8'h00, 1'b0, 1'b0, 8'h00},
		'{ROW_WORD, CFG_CIPHER_KEY,   10'h000, 8'hA5, 1'b0, 1'b0, 8'h00},
		// deciphering the first ciphertext from the zero iv gives back zero
		'{ROW_WORD, CFG_CIPHER_KEY,   10'h000, 8'hF0, 1'b1, 1'b1, 8'h00},
		'{ROW_CFG,  CFG_CIPHER_KEY,   10'h3FF, 8'h00, 1'b0, 1'b0, 8'h00},
		'{ROW_CFG,  CFG_INIT_VECTOR,  10'h0FF, 8'h00, 1'b0, 1'b0, 8'h00},
		'{ROW_WORD, CFG_CIPHER_KEY,   10'h000, 8'hFF, 1'b1, 1'b0, 8'h00},
		'{ROW_WORD, CFG_CIPHER_KEY,   10'h000, 8'h00, 1'b0, 1'b0, 8'h00},
		'{ROW_CFG,  CFG_DECRYPT_MODE, 10'h000, 8'h00, 1'b0, 1'b0, 8'h00},
		'{ROW_WORD, CFG_CIPHER_KEY,   10'h000, 8'h00, 1'b1, 1'b0, 8'h00},
		'{ROW_WORD, CFG_CIPHER_KEY,   10'h000, 8'hFF, 1'b0, 1'b0, 8'h00},
		// new iv must wait for the next message start
		'{ROW_CFG,  CFG_INIT_VECTOR,  10'h080, 8'h00, 1'b0, 1'b0, 8'h00},
		'{ROW_WORD, CFG_CIPHER_KEY,   10'h000, 8'h01, 1'b0, 1'b0, 8'h00},
		'{ROW_WORD, CFG_CIPHER_KEY,   10'h000, 8'h80, 1'b1, 1'b0, 8'h00},
		// key written mid-message, single key bits at both ends
		'{ROW_CFG,  CFG_CIPHER_KEY,   10'h200, 8'h00, 1'b0, 1'b0, 8'h00},
		'{ROW_WORD, CFG_CIPHER_KEY,   10'h000, 8'h7F, 1'b0, 1'b0, 8'h00},
		'{ROW_CFG,  CFG_CIPHER_KEY,   10'h001, 8'h00, 1'b0, 1'b0, 8'h00},
		'{ROW_CFG,  CFG_DECRYPT_MODE, 10'h001, 8'h00, 1'b0, 1'b0, 8'h00},
		'{ROW_WORD, CFG_CIPHER_KEY,   10'h000, 8'h01, 1'b1, 1'b0, 8'h00},
		'{ROW_WORD, CFG_CIPHER_KEY,   10'h000, 8'hFE, 1'b0, 1'b0, 8'h00}
	};

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	cfg_idx_t         cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_stall;
	byte_t            data_byte;
	logic             message_start;
	logic             out_valid;
	logic             out_stall;
	byte_t            result_byte;

	// predictor copy of the registers and the cbc chain
	key_t  key_reg;
	byte_t iv_reg;
	logic  dec_reg;
	byte_t chain_reg;

	byte_t result_bytes_due [$];

	int  mismatches;
	int  results_seen;
	int  words_sent;
	int  starts_sent;
	int  settings_used;
	bit  tx_quiet;
	bit  rx_quiet;
	bit  hold_off;
	bit  pressure_go;
	int  sink_gap;
	int  sink_seen;

	sdes_cbc_byte_cipher_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.message_start (message_start),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_byte   (result_byte)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	// subkey selections written out bit by bit, msb first
	function automatic byte_t first_subkey(input key_t k);
		return {k[9], k[3], k[1], k[6], k[2], k[7], k[0], k[4]};
	endfunction

	function automatic byte_t second_subkey(input key_t k);
		return {k[2], k[7], k[4], k[5], k[0], k[8], k[1], k[9]};
	endfunction

	// feistel function: expand the half, mix in the subkey, two s-boxes, p4
	function automatic half_t round_mix(input half_t h, input byte_t sk);
		byte_t      ep;
		logic [1:0] s0;
		logic [1:0] s1;
		ep = {h[0], h[3], h[2], h[1], h[2], h[1], h[0], h[3]} ^ sk;
		s0 = SBOX_ZERO[{ep[7], ep[4], ep[6], ep[5]}];
		s1 = SBOX_ONE[{ep[3], ep[0], ep[2], ep[1]}];
		return {s0[0], s1[0], s1[1], s0[1]};
	endfunction

	function automatic byte_t sdes_block(input byte_t b, input byte_t ka, input byte_t kb);
		byte_t ip;
		half_t mixed;
		half_t top;
		byte_t x;
		ip    = {b[6], b[2], b[5], b[7], b[4], b[0], b[3], b[1]};
		// first round, then the halves swap into the second round
		mixed = ip[7:4] ^ round_mix(ip[3:0], ka);
		top   = ip[3:0] ^ round_mix(mixed, kb);
		x     = {top, mixed};
		return {x[4], x[7], x[5], x[3], x[1], x[6], x[0], x[2]};
	endfunction

	// one word through cbc: encrypt chains on the output, decrypt on the input
	function automatic byte_t cbc_cipher_step(input byte_t d, input logic s);
		byte_t prev;
		byte_t res;
		prev = s ? iv_reg : chain_reg;
		if (dec_reg) begin
			res       = sdes_block(d, second_subkey(key_reg), first_subkey(key_reg)) ^ prev;
			chain_reg = d;
		end else begin
			res       = sdes_block(d ^ prev, first_subkey(key_reg), second_subkey(key_reg));
			chain_reg = res;
		end
		return res;
	endfunction

	// ---------------------------------------------------------------- driving

	// register writes happen only once every word in flight has come out;
	// the input side stays idle meanwhile
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
		in_valid <= 1'b0;
		while (result_bytes_due.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			CFG_CIPHER_KEY:   key_reg = val[KEY_W-1:0];
			CFG_INIT_VECTOR:  iv_reg  = val[BYTE_W-1:0];
			CFG_DECRYPT_MODE: dec_reg = val[0];
			default: ;
		endcase
	endtask

	// offer one word after a random gap; valid stays up into the next word
	// when that one has no gap
	task automatic send_word(input byte_t d, input logic s, input bit typed, input byte_t want);
		int    gap;
		byte_t predicted;
		gap = tx_quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid      <= 1'b1;
		data_byte     <= d;
		message_start <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		// accepted at this edge
		predicted = cbc_cipher_step(d, s);
		result_bytes_due.push_back(typed ? want : predicted);
		words_sent++;
		if (s) starts_sent++;
		@(negedge clk);
	endtask

	// ---------------------------------------------------------------- result side

	// receiver stalls for a random gap after each word, plus the long hold
	always @(negedge clk) begin
		if (results_seen != sink_seen) begin
			sink_seen = results_seen;
			sink_gap  = rx_quiet ? 0 : $urandom_range(0, 9);
		end
		if (sink_gap > 0) begin
			out_stall <= 1'b1;
			sink_gap--;
		end else begin
			out_stall <= hold_off;
		end
	end

	// long receiver hold-off so the core backs up and stalls its input
	initial begin
		hold_off = 1'b0;
		wait (pressure_go);
		@(negedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_off = 1'b0;
	end

	always @(posedge clk) begin
		byte_t due;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (result_bytes_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result word %02h at %0t", result_byte, $realtime);
			end else begin
				due = result_bytes_due.pop_front();
				if (result_byte !== due) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("result_byte mismatch at %0t: expected %02h, got %02h",
							$realtime, due, result_byte);
				end
			end
		end
	end

	// ---------------------------------------------------------------- main flow

	initial begin
		int          p;
		int          n;
		key_t        phase_key;
		byte_t       phase_iv;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_CIPHER_KEY;
		cfg_data      = '0;
		in_valid      = 1'b0;
		data_byte     = '0;
		message_start = 1'b0;
		out_stall     = 1'b0;
		key_reg       = '0;
		iv_reg        = '0;
		dec_reg       = 1'b0;
		chain_reg     = '0;
		mismatches    = 0;
		results_seen  = 0;
		sink_seen     = 0;
		sink_gap      = 0;
		words_sent    = 0;
		starts_sent   = 0;
		settings_used = 1;
		tx_quiet      = 1'b0;
		rx_quiet      = 1'b0;
		pressure_go   = 1'b0;

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			if (directed_rows[r].kind == ROW_CFG) begin
				write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_val);
				settings_used++;
			end else begin
				send_word(directed_rows[r].data, directed_rows[r].start,
					directed_rows[r].typed, directed_rows[r].want);
			end
		end

		// random phases, each under its own register setting; the first two take
		// the extremes, mode alternates so both directions get equal time
		for (p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 0) begin
				phase_key = '0;
				phase_iv  = '0;
			end else if (p == 1) begin
				phase_key = '1;
				phase_iv  = '1;
			end else begin
				phase_key = key_t'($urandom_range(0, 1023));
				phase_iv  = byte_t'($urandom_range(0, 255));
			end
			write_reg(CFG_CIPHER_KEY, CFG_W'(phase_key));
			write_reg(CFG_INIT_VECTOR, CFG_W'(phase_iv));
			write_reg(CFG_DECRYPT_MODE, CFG_W'(p % 2));
			settings_used++;

			// some phases run back to back on one or both sides
			tx_quiet = (p == 2) || (p == 5) || (p == PRESSURE_PHASE);
			rx_quiet = (p == 2) || (p == 6);
			if (p == PRESSURE_PHASE) pressure_go = 1'b1;

			for (n = 0; n < WORDS_PER_PHASE; n++) begin
				send_word(byte_t'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0),
					1'b0, 8'h00);
			end
		end
		in_valid <= 1'b0;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;

		// drain, then let the pipeline settle to catch stray words
		while (result_bytes_due.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);

		$display("ran %0d words (%0d message starts) through %0d register settings,",
			words_sent, starts_sent, settings_used);
		$display("both modes, key and iv extremes, long output hold; %0d results checked",
			results_seen);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatching or unexpected result words", mismatches);
			$display("== FAIL ==");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("timeout with %0d result words still due", result_bytes_due.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
